@@ hw/rtl/utc_to_local_time_bcd_core_defines.svh @@
// ----------------------------------------------------------------------------
// UTC to local time converter: assertion macros
// Shared concurrent assertion forms, clocked on clk and muted during reset.
// ----------------------------------------------------------------------------
`ifndef UTC_TO_LOCAL_TIME_BCD_CORE_DEFINES_SVH
`define UTC_TO_LOCAL_TIME_BCD_CORE_DEFINES_SVH

// Same-cycle implication.
`define UTLT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define UTLT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/utlt_pkg.sv @@
// ----------------------------------------------------------------------------
// UTC to local time converter: package
// Item types, register map constants and the calendar helper functions.
// ----------------------------------------------------------------------------
package utlt_pkg;

  // Configuration port: one register, index taken from paddr[2].
  localparam int unsigned CFG_ADDR_W       = 3;
  localparam int unsigned CFG_DATA_W       = 32;
  localparam logic        CFG_IDX_EARLIEST = 1'b0;
  localparam logic [6:0]  EARLIEST_YEAR_RST = 7'd17;

  localparam logic [4:0] MONTH_DAYS [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef struct packed {
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic       zone_minus;
    logic [6:0] zone_quarters;
  } utlt_in_t;

  typedef struct packed {
    logic [7:0] bcd_year;
    logic [7:0] bcd_month;
    logic [7:0] bcd_day;
    logic [7:0] bcd_hour;
    logic [7:0] bcd_minute;
    logic [7:0] bcd_second;
    logic       time_valid;
  } utlt_out_t;

  // Month length; a month outside 1..12 counts as 31 days.
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    if (m < 4'd1 || m > 4'd12) begin
      len = 5'd31;
    end else if (m == 4'd2 && leap) begin
      len = 5'd29;
    end else begin
      len = MONTH_DAYS[m - 4'd1];
    end
    return len;
  endfunction

  // Two BCD digits of a value below 100.
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [3:0] tens;
    logic [6:0] ones;
    tens = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (v >= 7'(k * 10)) begin
        tens = tens + 4'd1;
      end
    end
    ones = v - 7'({3'b000, tens} * 7'd10);
    return {tens, ones[3:0]};
  endfunction

endpackage

@@ hw/rtl/utlt_if.sv @@
// ----------------------------------------------------------------------------
// UTC to local time converter: stream interfaces
// Valid/ready channels for the UTC input items and the local BCD results.
// ----------------------------------------------------------------------------
interface utlt_in_if;
  logic               valid;
  logic               ready;
  utlt_pkg::utlt_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface utlt_out_if;
  logic                valid;
  logic                ready;
  utlt_pkg::utlt_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/utc_to_local_time_bcd_core.sv @@
// ----------------------------------------------------------------------------
// UTC to local time converter: top level
// Converts a binary UTC timestamp and zone offset into local time in BCD.
// ----------------------------------------------------------------------------
// Usage:
// Items arrive on in_ch (valid/ready) and carry a UTC date, time, zone sign and
// zone offset in quarter hours. Each item yields exactly one result on out_ch
// with the local date and time as BCD digits plus a validity flag.
// The path is an input register, the conversion logic and an output register:
// an accepted item waits in the input register and its result moves to the
// output register once that is free or drains. One item is accepted every
// cycle as long as results are taken.
// When out_ch is stalled the result is held stable; the input register still
// takes one more item, after which in_ch.ready drops until the result leaves.
// The APB port holds earliest_year at address 0; it is written in the access
// phase and read back on prdata with no wait states.
// A synchronous low rst_n empties both registers and sets earliest_year to 17.
// ----------------------------------------------------------------------------
module utc_to_local_time_bcd_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  utlt_in_if.sink                              in_ch,
  utlt_out_if.source                           out_ch,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [utlt_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [utlt_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [utlt_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                 pready
);

  logic [6:0]          earliest_year_r;
  logic                s1_valid_r;
  utlt_pkg::utlt_in_t  s1_data_r;
  logic                out_valid_r;
  utlt_pkg::utlt_out_t out_data_r;
  utlt_pkg::utlt_out_t conv_res;
  logic                s1_adv;
  logic                in_take;
  logic                cfg_wr;
  logic                cfg_sel_earliest;

  assign cfg_sel_earliest = (paddr[2] == utlt_pkg::CFG_IDX_EARLIEST);
  assign cfg_wr           = psel && penable && pwrite;
  assign pready           = 1'b1;
  assign prdata           = cfg_sel_earliest ?
                            {{(utlt_pkg::CFG_DATA_W-7){1'b0}}, earliest_year_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      earliest_year_r <= utlt_pkg::EARLIEST_YEAR_RST;
    end else if (cfg_wr && cfg_sel_earliest) begin
      earliest_year_r <= pwdata[6:0];
    end
  end

  // The input register advances whenever the output register is free or drains.
  assign s1_adv       = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || s1_adv;
  assign in_take      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (!out_valid_r || out_ch.ready) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_ch.data;
    end
    if (s1_adv) begin
      out_data_r <= conv_res;
    end
  end

  utlt_conv u_conv (
    .item          (s1_data_r),
    .earliest_year (earliest_year_r),
    .res           (conv_res)
  );

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

endmodule

@@ hw/rtl/utlt_conv.sv @@
// ----------------------------------------------------------------------------
// UTC to local time converter: conversion logic
// Applies the whole-hour zone offset with a single day, month and year carry
// or borrow, then range checks and encodes every field as two BCD digits.
// ----------------------------------------------------------------------------
module utlt_conv (
  input  utlt_pkg::utlt_in_t  item,
  input  logic [6:0]          earliest_year,
  output utlt_pkg::utlt_out_t res
);

  logic       leap;
  logic [4:0] offs;
  logic [4:0] len_cur;
  logic [4:0] len_prev;
  logic [5:0] hr_sum;
  logic [5:0] hr_wrap;
  logic [5:0] day_inc;
  logic [4:0] mon_inc;
  logic [7:0] yr_raw;
  logic [5:0] hr_f;
  logic [5:0] dy_f;
  logic [3:0] mo_f;
  logic [6:0] yr_f;

  // 2000 + year is a leap year for every fourth year except 2100.
  assign leap     = (item.year[1:0] == 2'b00) && (item.year != 7'd100);
  assign offs     = item.zone_quarters[6:2];
  assign len_cur  = utlt_pkg::month_len(item.month, leap);
  assign len_prev = utlt_pkg::month_len(item.month - 4'd1, leap);
  assign hr_sum   = {1'b0, item.hour} + {1'b0, offs};
  // Only used when hour < offset, so the value lies in 17..47.
  assign hr_wrap  = {1'b0, item.hour} + 6'd48 - {1'b0, offs};
  assign day_inc  = {1'b0, item.day} + 6'd1;
  assign mon_inc  = {1'b0, item.month} + 5'd1;

  always_comb begin
    hr_f   = {1'b0, item.hour};
    dy_f   = {1'b0, item.day};
    mo_f   = item.month;
    yr_raw = {1'b0, item.year};
    if (!item.zone_minus) begin
      if (hr_sum >= 6'd48) begin
        hr_f = hr_sum - 6'd48;
      end else if (hr_sum >= 6'd24) begin
        hr_f = hr_sum - 6'd24;
      end else begin
        hr_f = hr_sum;
      end
      if (hr_sum >= 6'd24) begin
        dy_f = day_inc;
        if (day_inc > {1'b0, len_cur}) begin
          dy_f = day_inc - {1'b0, len_cur};
          if (mon_inc > 5'd12) begin
            mo_f   = 4'(mon_inc - 5'd12);
            yr_raw = {1'b0, item.year} + 8'd1;
          end else begin
            mo_f = mon_inc[3:0];
          end
        end
      end
    end else if (item.hour >= offs) begin
      hr_f = {1'b0, item.hour - offs};
    end else begin
      hr_f = (hr_wrap >= 6'd24) ? hr_wrap - 6'd24 : hr_wrap;
      if (item.day <= 5'd1) begin
        if (item.month <= 4'd1) begin
          // Borrow below January lands on December 31 of the year before.
          mo_f   = 4'd12;
          dy_f   = 6'd31;
          yr_raw = (item.year == 7'd0) ? 8'd99 : {1'b0, item.year} - 8'd1;
        end else begin
          mo_f = item.month - 4'd1;
          dy_f = {1'b0, len_prev};
        end
      end else begin
        dy_f = {1'b0, item.day} - 6'd1;
      end
    end
  end

  assign yr_f = (yr_raw >= 8'd100) ? 7'(yr_raw - 8'd100) : yr_raw[6:0];

  always_comb begin
    res.bcd_year   = utlt_pkg::to_bcd(yr_f);
    res.bcd_month  = utlt_pkg::to_bcd({3'b000, mo_f});
    res.bcd_day    = utlt_pkg::to_bcd({1'b0, dy_f});
    res.bcd_hour   = utlt_pkg::to_bcd({1'b0, hr_f});
    res.bcd_minute = utlt_pkg::to_bcd({1'b0, item.minute});
    res.bcd_second = utlt_pkg::to_bcd({1'b0, item.second});
    res.time_valid = (yr_f >= earliest_year) &&
                     (mo_f >= 4'd1) && (mo_f <= 4'd12) &&
                     (dy_f >= 6'd1) && (dy_f <= 6'd31) &&
                     (hr_f < 6'd24) && (item.minute < 6'd60) &&
                     (item.second < 6'd60);
  end

endmodule

@@ hw/rtl/utlt_chk.sv @@
// ----------------------------------------------------------------------------
// UTC to local time converter: port checker
// Watches the top level's result channel and the shape of the BCD results.
// ----------------------------------------------------------------------------
`include "utc_to_local_time_bcd_core_defines.svh"

module utlt_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input utlt_pkg::utlt_out_t out_data
);

  `UTLT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

  `UTLT_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_data), "result changed while stalled")

  // Fields are below 100; checks both year digits and each low digit.
  `UTLT_ASSERT_NOW(a_bcd_digits, out_valid, (out_data.bcd_year[3:0] <= 4'd9) && (out_data.bcd_year[7:4] <= 4'd9) && (out_data.bcd_month[3:0] <= 4'd9) && (out_data.bcd_day[3:0] <= 4'd9) && (out_data.bcd_hour[3:0] <= 4'd9) && (out_data.bcd_minute[3:0] <= 4'd9) && (out_data.bcd_second[3:0] <= 4'd9), "result holds a non-decimal digit")

  // A result flagged valid must carry calendar values in range.
  `UTLT_ASSERT_NOW(a_valid_range, out_valid && out_data.time_valid, (out_data.bcd_month != 8'h00) && (out_data.bcd_month <= 8'h12) && (out_data.bcd_day != 8'h00) && (out_data.bcd_hour < 8'h24) && (out_data.bcd_minute < 8'h60) && (out_data.bcd_second < 8'h60), "valid result out of range")

endmodule

bind utc_to_local_time_bcd_core utlt_chk u_utlt_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// UTC to local time converter: testbench
// Sends UTC timestamps with zone offsets through the stream input and checks
// every local BCD result in order against a calendar predictor. It moves
// earliest_year through several settings over the APB port, and both stream
// sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned ITEMS_PER_PHASE = 260;
  localparam int unsigned IN_W = $bits(utlt_pkg::utlt_in_t);
  localparam logic [utlt_pkg::CFG_ADDR_W-1:0] EARLIEST_YEAR_ADDR =
    utlt_pkg::CFG_ADDR_W'(4 * utlt_pkg::CFG_IDX_EARLIEST);

  class local_time_scoreboard;
    utlt_pkg::utlt_out_t expected_q[$];
    logic [6:0]          earliest_year;
    int unsigned         mismatches;
    int unsigned         checked;

    function new();
      earliest_year = utlt_pkg::EARLIEST_YEAR_RST;
      mismatches = 0;
      checked = 0;
    endfunction

    function int unsigned days_in_month(int unsigned m, bit leap);
      int unsigned n;
      case (m)
        2: begin
          n = leap ? 29 : 28;
        end
        4, 6, 9, 11: begin
          n = 30;
        end
        // Months outside 1..12 fall here as well and count as 31 days.
        default: begin
          n = 31;
        end
      endcase
      return n;
    endfunction

    function logic [7:0] bcd_pair(int unsigned v);
      int unsigned r;
      r = v % 100;
      return {4'(r / 10), 4'(r % 10)};
    endfunction

    function utlt_pkg::utlt_out_t convert(utlt_pkg::utlt_in_t t);
      int unsigned yr, mo, dy, hr, offs, len, full;
      bit leap, ok;
      utlt_pkg::utlt_out_t r;
      yr = t.year;
      mo = t.month;
      dy = t.day;
      hr = t.hour;
      offs = t.zone_quarters / 4;
      // The leap rule uses the UTC year, before any carry or borrow.
      full = 2000 + yr;
      leap = ((full % 4 == 0) && (full % 100 != 0)) || (full % 400 == 0);
      if (!t.zone_minus) begin
        hr = hr + offs;
        if (hr >= 24) begin
          hr = hr % 24;
          dy = dy + 1;
          len = days_in_month(mo, leap);
          if (dy > len) begin
            dy = dy % len;
            mo = mo + 1;
            if (mo > 12) begin
              mo = mo % 12;
              yr = yr + 1;
            end
          end
        end
      end else begin
        if (hr >= offs) begin
          hr = hr - offs;
        end else begin
          hr = (hr + 48 - offs) % 24;
          if (dy <= 1) begin
            if (mo <= 1) begin
              mo = 12;
              dy = 31;
              yr = (yr == 0) ? 99 : yr - 1;
            end else begin
              mo = mo - 1;
              dy = days_in_month(mo, leap);
            end
          end else begin
            dy = dy - 1;
          end
        end
      end
      yr = yr % 100;
      ok = (yr >= earliest_year) && (mo >= 1) && (mo <= 12) && (dy >= 1) && (dy <= 31) &&
           (hr < 24) && (t.minute < 60) && (t.second < 60);
      r.bcd_year   = bcd_pair(yr);
      r.bcd_month  = bcd_pair(mo);
      r.bcd_day    = bcd_pair(dy);
      r.bcd_hour   = bcd_pair(hr);
      r.bcd_minute = bcd_pair(t.minute);
      r.bcd_second = bcd_pair(t.second);
      r.time_valid = ok;
      return r;
    endfunction

    function void note_item(utlt_pkg::utlt_in_t t);
      expected_q.push_back(convert(t));
    endfunction

    function void check_field(string name, int unsigned exp, int unsigned got);
      if (exp != got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, exp, got);
        mismatches++;
      end
    endfunction

    function void check_result(utlt_pkg::utlt_out_t got);
      utlt_pkg::utlt_out_t exp;
      if (expected_q.size() == 0) begin
        $error("result arrived with no item outstanding");
        mismatches++;
        return;
      end
      exp = expected_q.pop_front();
      checked++;
      check_field("bcd_year", exp.bcd_year, got.bcd_year);
      check_field("bcd_month", exp.bcd_month, got.bcd_month);
      check_field("bcd_day", exp.bcd_day, got.bcd_day);
      check_field("bcd_hour", exp.bcd_hour, got.bcd_hour);
      check_field("bcd_minute", exp.bcd_minute, got.bcd_minute);
      check_field("bcd_second", exp.bcd_second, got.bcd_second);
      check_field("time_valid", exp.time_valid, got.time_valid);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic psel, penable, pwrite, pready;
  logic [utlt_pkg::CFG_ADDR_W-1:0] paddr;
  logic [utlt_pkg::CFG_DATA_W-1:0] pwdata, prdata;

  utlt_in_if  in_ch();
  utlt_out_if out_ch();

  local_time_scoreboard sb = new();
  bit          gaps_on = 1'b1;
  bit          stalls_on = 1'b1;
  int unsigned quiet_cycles = 0;
  int unsigned settings_seen = 0;

  utc_to_local_time_bcd_core i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Result side: accepts most cycles, stalls at random while stalls are enabled.
  always @(posedge clk) begin
    if (!stalls_on) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= 32);
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      sb.note_item(in_ch.data);
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_result(out_ch.data);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (psel && penable && pready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles", QUIET_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function utlt_pkg::utlt_in_t stamp(int unsigned yr, int unsigned mo, int unsigned dy,
                                     int unsigned hr, int unsigned mi, int unsigned se,
                                     bit minus, int unsigned q);
    utlt_pkg::utlt_in_t t;
    t.year = 7'(yr);
    t.month = 4'(mo);
    t.day = 5'(dy);
    t.hour = 5'(hr);
    t.minute = 6'(mi);
    t.second = 6'(se);
    t.zone_minus = minus;
    t.zone_quarters = 7'(q);
    return t;
  endfunction

  // Mostly calendar-valid timestamps leaning toward month ends and the day
  // boundary, so that carries and borrows are frequent; the rest is raw bits.
  function utlt_pkg::utlt_in_t random_timestamp();
    utlt_pkg::utlt_in_t t;
    if ($urandom_range(99) < 20) begin
      t = IN_W'({$urandom, $urandom});
    end else begin
      t.year = 7'($urandom_range(99));
      t.month = 4'($urandom_range(1, 12));
      t.day = ($urandom_range(1) == 0) ? 5'($urandom_range(1, 31))
                                       : 5'($urandom_range(27, 32) % 32);
      t.hour = ($urandom_range(1) == 0) ? 5'($urandom_range(23))
                                        : 5'($urandom_range(3) < 2 ? $urandom_range(2)
                                                                   : $urandom_range(21, 23));
      t.minute = 6'($urandom_range(59));
      t.second = 6'($urandom_range(59));
      t.zone_minus = 1'($urandom_range(1));
      t.zone_quarters = 7'($urandom_range(99));
    end
    return t;
  endfunction

  task automatic send_stamp(input utlt_pkg::utlt_in_t t);
    if (gaps_on && $urandom_range(99) < 32) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while (gaps_on && $urandom_range(99) < 32);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= t;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic wait_drained();
    while (sb.expected_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  // Writes earliest_year, then reads it back in the same APB selection.
  task automatic set_earliest_year(input int unsigned v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= EARLIEST_YEAR_ADDR;
    pwdata <= utlt_pkg::CFG_DATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.earliest_year = 7'(v);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata != utlt_pkg::CFG_DATA_W'(v)) begin
      $error("earliest_year readback: expected 0x%0h, got 0x%0h", v, prdata);
      sb.mismatches++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    settings_seen++;
  endtask

  initial begin
    utlt_pkg::utlt_in_t directed[$];
    int unsigned        plan[5];
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed items under the reset value of earliest_year.
    directed.push_back(stamp(24, 2, 28, 20, 0, 0, 0, 32));    // leap February rolls to the 29th
    directed.push_back(stamp(23, 2, 28, 20, 0, 0, 0, 32));    // common year goes to March 1
    directed.push_back(stamp(24, 2, 29, 23, 59, 59, 0, 4));
    directed.push_back(stamp(99, 12, 31, 23, 59, 59, 0, 99)); // year wraps to 00
    directed.push_back(stamp(30, 1, 1, 0, 30, 30, 1, 20));    // borrow below January
    directed.push_back(stamp(0, 1, 1, 2, 0, 0, 1, 12));       // year 00 borrows to 99
    directed.push_back(stamp(25, 3, 1, 3, 0, 0, 1, 16));
    directed.push_back(stamp(24, 3, 1, 3, 0, 0, 1, 16));
    directed.push_back(stamp(25, 5, 0, 1, 0, 0, 1, 8));       // borrow from day zero
    directed.push_back(stamp(25, 0, 10, 1, 0, 0, 1, 8));
    directed.push_back(stamp(25, 0, 1, 1, 0, 0, 1, 8));
    directed.push_back(stamp(25, 13, 31, 23, 0, 0, 0, 4));    // month past 12 counts 31 days
    directed.push_back(stamp(25, 15, 31, 31, 63, 63, 0, 127));
    directed.push_back(stamp(25, 6, 15, 0, 0, 0, 1, 127));    // offset larger than the hour
    directed.push_back(stamp(25, 4, 31, 22, 0, 0, 0, 16));    // day past the month length
    directed.push_back(stamp(100, 2, 28, 23, 0, 0, 0, 4));    // 2100 is not a leap year
    directed.push_back(stamp(127, 15, 31, 31, 63, 63, 1, 127));
    directed.push_back(stamp(0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(stamp(17, 6, 15, 12, 0, 0, 0, 0));
    directed.push_back(stamp(16, 6, 15, 12, 0, 0, 0, 0));
    directed.push_back(stamp(25, 6, 15, 31, 0, 0, 1, 0));
    directed.push_back(stamp(96, 2, 28, 23, 0, 0, 0, 7));     // quarters round down to hours
    directed.push_back(stamp(28, 12, 31, 10, 0, 0, 1, 40));
    foreach (directed[k]) begin
      send_stamp(directed[k]);
    end
    in_ch.valid <= 1'b0;
    wait_drained();

    plan[0] = 0;
    plan[1] = 99;
    plan[2] = $urandom_range(1, 98);
    plan[3] = 17;
    plan[4] = $urandom_range(99);
    foreach (plan[p]) begin
      set_earliest_year(plan[p]);
      // One whole phase runs at full rate on both sides.
      gaps_on = (p != 2);
      stalls_on = (p != 2);
      repeat (ITEMS_PER_PHASE) send_stamp(random_timestamp());
      in_ch.valid <= 1'b0;
      gaps_on = 1'b1;
      stalls_on = 1'b1;
      wait_drained();
    end
    repeat (8) @(posedge clk);

    $display("Checked %0d local time results across %0d earliest_year settings.",
             sb.checked, settings_seen + 1);
    if (sb.expected_q.size() != 0) begin
      $error("%0d expected results never arrived", sb.expected_q.size());
      sb.mismatches++;
    end
    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/utlt_pkg.sv
hw/rtl/utlt_if.sv
hw/rtl/utlt_conv.sv
hw/rtl/utc_to_local_time_bcd_core.sv
hw/rtl/utlt_chk.sv
verif/testbench.sv
